>>> rtl/dns_query_name_parser_assert.svh
// Assertion macros shared by the DNS question-name parser RTL.
`ifndef DNS_QUERY_NAME_PARSER_ASSERT_SVH
`define DNS_QUERY_NAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DQNP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DQNP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dqnp_pkg.sv
// Types and constants of the DNS question-name parser.
package dqnp_pkg;

  localparam int unsigned HEADER_BYTES = 12;
  localparam logic [7:0]  LEN_RSVD_MASK = 8'hc0;
  localparam logic [2:0]  TAIL_BYTES = 3'd4;
  localparam logic [7:0]  DOT_CHAR = 8'h2e;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_LEN    = 3'd1,
    PH_LABEL  = 3'd2,
    PH_TAIL   = 3'd3,
    PH_DONE   = 3'd4
  } phase_e;

  // Fixed-width part of the parse context.
  typedef struct packed {
    phase_e      phase;
    logic [5:0]  label_left;
    logic [2:0]  tail_count;
    logic [7:0]  type_hi;
    logic [15:0] qtype;
    logic        failed;
  } ctx_t;

  // One result beat.
  typedef struct packed {
    logic        char_valid;
    logic [7:0]  name_char;
    logic        message_end;
    logic        decode_ok;
    logic [15:0] qtype_out;
    logic        keep_event;
  } res_t;

endpackage

>>> rtl/dqnp_step.sv
// Per-byte parse step: next context and result from the current context and one byte.
module dqnp_step #(
  parameter int unsigned MAX_MESSAGE_BYTES = 512,
  parameter int unsigned NAME_CAPACITY     = 256,
  localparam int unsigned POS_W  = $clog2(MAX_MESSAGE_BYTES),
  localparam int unsigned NLEN_W = $clog2(NAME_CAPACITY)
) (
  input  logic [7:0]        data_byte_i,
  input  logic              last_byte_i,
  input  logic              is_response_i,
  input  logic [15:0]       event_query_type_i,
  input  logic [POS_W-1:0]  pos_i,
  input  logic [NLEN_W-1:0] nlen_i,
  input  dqnp_pkg::ctx_t    ctx_i,
  output logic [POS_W-1:0]  pos_o,
  output logic [NLEN_W-1:0] nlen_o,
  output dqnp_pkg::ctx_t    ctx_o,
  output dqnp_pkg::res_t    res_o
);

  localparam logic [POS_W-1:0]  PosLast  = POS_W'(MAX_MESSAGE_BYTES - 1);
  localparam logic [POS_W-1:0]  HdrLast  = POS_W'(dqnp_pkg::HEADER_BYTES - 1);
  localparam logic [NLEN_W:0]   CapLimit = (NLEN_W+1)'(NAME_CAPACITY);

  dqnp_pkg::ctx_t    ctx_d;
  dqnp_pkg::res_t    char_res;
  logic [NLEN_W-1:0] nlen_d;
  logic [NLEN_W:0]   nlen_inc;
  logic              cap_hit;
  logic              ok;
  logic [15:0]       qt;

  assign nlen_inc = {1'b0, nlen_i} + (NLEN_W+1)'(1);
  assign cap_hit  = (nlen_inc >= CapLimit);

  always_comb begin
    ctx_d = ctx_i;
    nlen_d = nlen_i;
    char_res = '0;

    if (!last_byte_i && (pos_i >= PosLast)) begin
      ctx_d.failed = 1'b1;
    end

    if (!ctx_d.failed) begin
      unique case (ctx_i.phase)
        dqnp_pkg::PH_HEADER: begin
          if (pos_i >= HdrLast) begin
            ctx_d.phase = dqnp_pkg::PH_LEN;
          end
        end
        dqnp_pkg::PH_LEN: begin
          if (data_byte_i == 8'd0) begin
            // root name: emit a lone dot
            if (nlen_i == '0) begin
              char_res.char_valid = 1'b1;
              char_res.name_char = dqnp_pkg::DOT_CHAR;
              nlen_d = NLEN_W'(1);
            end
            ctx_d.phase = dqnp_pkg::PH_TAIL;
            ctx_d.tail_count = '0;
          end else if ((data_byte_i & dqnp_pkg::LEN_RSVD_MASK) != 8'd0) begin
            ctx_d.failed = 1'b1;
          end else if ((nlen_i != '0) && cap_hit) begin
            ctx_d.failed = 1'b1;
          end else begin
            if (nlen_i != '0) begin
              char_res.char_valid = 1'b1;
              char_res.name_char = dqnp_pkg::DOT_CHAR;
              nlen_d = NLEN_W'(nlen_inc);
            end
            ctx_d.label_left = data_byte_i[5:0];
            ctx_d.phase = dqnp_pkg::PH_LABEL;
          end
        end
        dqnp_pkg::PH_LABEL: begin
          if (cap_hit) begin
            ctx_d.failed = 1'b1;
          end else begin
            char_res.char_valid = 1'b1;
            char_res.name_char = data_byte_i;
            nlen_d = NLEN_W'(nlen_inc);
            ctx_d.label_left = ctx_i.label_left - 6'd1;
            if (ctx_i.label_left == 6'd1) begin
              ctx_d.phase = dqnp_pkg::PH_LEN;
            end
          end
        end
        dqnp_pkg::PH_TAIL: begin
          if (ctx_i.tail_count == 3'd0) begin
            ctx_d.type_hi = data_byte_i;
          end else if (ctx_i.tail_count == 3'd1) begin
            ctx_d.qtype = {ctx_i.type_hi, data_byte_i};
          end
          ctx_d.tail_count = ctx_i.tail_count + 3'd1;
          if (ctx_d.tail_count >= dqnp_pkg::TAIL_BYTES) begin
            ctx_d.phase = dqnp_pkg::PH_DONE;
          end
        end
        default: ;
      endcase
    end
  end

  assign ok = !ctx_d.failed && (ctx_d.phase == dqnp_pkg::PH_DONE);
  assign qt = ok ? ctx_d.qtype : event_query_type_i;

  always_comb begin
    res_o = char_res;
    // report the message status on the last beat only
    if (last_byte_i) begin
      res_o.message_end = 1'b1;
      res_o.decode_ok   = ok;
      res_o.qtype_out   = qt;
      res_o.keep_event  = is_response_i || (ok && (qt != 16'd0));
    end
  end

  always_comb begin
    if (last_byte_i) begin
      // close the message and return to the reset context
      pos_o  = '0;
      nlen_o = '0;
      ctx_o  = '{phase: dqnp_pkg::PH_HEADER, default: '0};
    end else begin
      pos_o  = (pos_i < PosLast) ? pos_i + POS_W'(1) : pos_i;
      nlen_o = nlen_d;
      ctx_o  = ctx_d;
    end
  end

endmodule

>>> rtl/dqnp_out_reg.sv
// Result register with valid/ready handshake toward the consumer.
module dqnp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  dqnp_pkg::res_t res_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic           can_load_o,
  output dqnp_pkg::res_t res_o
);

  logic           valid_q;
  logic           valid_d;
  dqnp_pkg::res_t res_q;

  // take a new beat when empty or when the held one leaves this cycle
  assign can_load_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

>>> rtl/dns_query_name_parser.sv
// Top level of the DNS question-name parser: context registers, step logic, result register.
//
//   channel | direction | handshake               | beat payload
//   in      | sink      | in_valid_i / in_ready_o | data_byte, last_byte, is_response,
//           |           |                         | event_query_type
//   out     | source    | out_valid_o/out_ready_i | char_valid, name_char, message_end,
//           |           |                         | decode_ok, query_type_out, keep_event
//
// One byte per cycle unless out stalls; each accepted beat yields exactly one result beat.
// The context update is a single combinational step between the context registers
// and the result register.
// Reset clears the context to the header phase and empties the result register.
// A stalled consumer holds the result; input is taken again as the result leaves.
`include "dns_query_name_parser_assert.svh"

module dns_query_name_parser #(
  parameter int unsigned MAX_MESSAGE_BYTES = 512,
  parameter int unsigned NAME_CAPACITY     = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        is_response_i,
  input  logic [15:0] event_query_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        char_valid_o,
  output logic [7:0]  name_char_o,
  output logic        message_end_o,
  output logic        decode_ok_o,
  output logic [15:0] query_type_out_o,
  output logic        keep_event_o
);

  localparam int unsigned POS_W  = $clog2(MAX_MESSAGE_BYTES);
  localparam int unsigned NLEN_W = $clog2(NAME_CAPACITY);

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [NLEN_W-1:0] nlen_q, nlen_d;
  dqnp_pkg::ctx_t    ctx_q, ctx_d;
  dqnp_pkg::res_t    res_d, res_q;
  logic              in_accept;

  assign in_accept = in_valid_i && in_ready_o;

  dqnp_step #(
    .MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES),
    .NAME_CAPACITY    (NAME_CAPACITY)
  ) u_step (
    .data_byte_i       (data_byte_i),
    .last_byte_i       (last_byte_i),
    .is_response_i     (is_response_i),
    .event_query_type_i(event_query_type_i),
    .pos_i             (pos_q),
    .nlen_i            (nlen_q),
    .ctx_i             (ctx_q),
    .pos_o             (pos_d),
    .nlen_o            (nlen_d),
    .ctx_o             (ctx_d),
    .res_o             (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      nlen_q <= '0;
      ctx_q  <= '{phase: dqnp_pkg::PH_HEADER, default: '0};
    end else if (in_accept) begin
      pos_q  <= pos_d;
      nlen_q <= nlen_d;
      ctx_q  <= ctx_d;
    end
  end

  dqnp_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_accept),
    .res_i      (res_d),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .can_load_o (in_ready_o),
    .res_o      (res_q)
  );

  assign char_valid_o     = res_q.char_valid;
  assign name_char_o      = res_q.name_char;
  assign message_end_o    = res_q.message_end;
  assign decode_ok_o      = res_q.decode_ok;
  assign query_type_out_o = res_q.qtype_out;
  assign keep_event_o     = res_q.keep_event;

  `DQNP_ASSERT_NXT(a_last_resets_ctx, in_accept && last_byte_i,
    pos_q == '0 && nlen_q == '0 && ctx_q.phase == dqnp_pkg::PH_HEADER && !ctx_q.failed,
    "context not cleared after last byte")
  `DQNP_ASSERT_NXT(a_failed_no_char, in_accept && ctx_q.failed,
    !char_valid_o, "name character emitted after failure")
  `DQNP_ASSERT_IMP(a_status_only_at_end, out_valid_o && !message_end_o,
    !decode_ok_o && !keep_event_o && query_type_out_o == 16'd0,
    "status fields set on a non-final beat")
  `DQNP_ASSERT_IMP(a_pos_saturates, 1'b1,
    pos_q <= POS_W'(MAX_MESSAGE_BYTES - 1), "byte position beyond message limit")

endmodule
